FILE: rtl/i2cts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cts_pkg;

   typedef enum logic [1:0] {
      KIND_BEGIN = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_BUS   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_START   = 3'd1,
      ACT_TX      = 3'd2,
      ACT_RX_ACK  = 3'd3,
      ACT_RX_NACK = 3'd4,
      ACT_STOP    = 3'd5,
      ACT_REQ     = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      OUT_SUCCESS = 2'd0,
      OUT_NAK     = 2'd1,
      OUT_ERROR   = 2'd2
   } outcome_type;

   localparam logic [7:0] ST_START     = 8'h08;
   localparam logic [7:0] ST_RSTART    = 8'h10;
   localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
   localparam logic [7:0] ST_SLAW_NAK  = 8'h20;
   localparam logic [7:0] ST_TX_ACK    = 8'h28;
   localparam logic [7:0] ST_TX_NAK    = 8'h30;
   localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
   localparam logic [7:0] ST_SLAR_NAK  = 8'h48;
   localparam logic [7:0] ST_RX_ACK    = 8'h50;
   localparam logic [7:0] ST_RX_NACK   = 8'h58;
   localparam logic [7:0] ADDR_WR_MASK = 8'hFE;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  device_address;
      logic [15:0] write_count;
      logic [15:0] read_count;
      logic [7:0]  write_byte;
      logic [7:0]  bus_status;
      logic [7:0]  received_byte;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  transmit_byte;
      logic [7:0]  read_byte;
      logic        read_valid;
      logic        done_res;
      outcome_type outcome;
      logic [7:0]  failing_status;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/i2c_master_transaction_sequencer.sv
// I2C master transaction sequencer, byte level.
// Request channel (req_valid / req_stall): one event per request. A begin
// request latches the address byte and the write and read counts; a write
// request supplies the next byte asked for; a bus request reports the
// status (and received byte) of the last bus operation.
// Response channel (rsp_valid / rsp_stall): exactly one response per request,
// carrying the next bus action, transmit byte, any received byte, and on the
// last response of a transaction done_res with outcome and failing status.
// A request taken into the request register passes through the state logic
// into the response register once that register is open, raising rsp_valid.
// One request is accepted every cycle while req_stall is low: a request
// register and a response register bracket one pass of the state logic.
// A stalled response holds; the request register still drains into the
// response register once it is taken, so req_stall rises only while both are
// full and the response is stalled.
// Reset clears the transaction state to idle and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_transaction_sequencer
   import i2cts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_device_address,
   input  wire logic [15:0] req_write_count,
   input  wire logic [15:0] req_read_count,
   input  wire logic [7:0]  req_write_byte,
   input  wire logic [7:0]  req_bus_status,
   input  wire logic [7:0]  req_received_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_action,
   output logic [7:0]       rsp_transmit_byte,
   output logic [7:0]       rsp_read_byte,
   output logic             rsp_read_valid,
   output logic             rsp_done_res,
   output logic [1:0]       rsp_outcome,
   output logic [7:0]       rsp_failing_status
);

   req_type req_ff;
   logic    req_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;
   logic    rsp_open;
   logic    step_en;
   logic    req_take;

   assign rsp_open  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = req_valid_ff && rsp_open;
   assign req_stall = req_valid_ff && !rsp_open;
   assign req_take  = req_valid && !req_stall;

   i2cts_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (req_ff),
      .rsp     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (rsp_open) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
      if (req_take) begin
         req_ff <= '{kind:           req_kind,
                     device_address: req_device_address,
                     write_count:    req_write_count,
                     read_count:     req_read_count,
                     write_byte:     req_write_byte,
                     bus_status:     req_bus_status,
                     received_byte:  req_received_byte};
      end
      if (step_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = rsp_ff.action;
   assign rsp_transmit_byte  = rsp_ff.transmit_byte;
   assign rsp_read_byte      = rsp_ff.read_byte;
   assign rsp_read_valid     = rsp_ff.read_valid;
   assign rsp_done_res       = rsp_ff.done_res;
   assign rsp_outcome        = rsp_ff.outcome;
   assign rsp_failing_status = rsp_ff.failing_status;

endmodule

`default_nettype wire

FILE: rtl/i2cts_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cts_engine
   import i2cts_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire req_type req,
   output rsp_type      rsp
);

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_W_START = 4'd1,
      PH_W_SLA   = 4'd2,
      PH_W_NEED  = 4'd3,
      PH_W_DATA  = 4'd4,
      PH_R_START = 4'd5,
      PH_R_SLA   = 4'd6,
      PH_R_ACK   = 4'd7,
      PH_R_NACK  = 4'd8
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] writes_left_ff, writes_left_in;
   logic [15:0] reads_left_ff, reads_left_in;
   logic        wrote_flag_ff, wrote_flag_in;
   logic [7:0]  address_byte_ff, address_byte_in;
   logic [15:0] reads_dec;
   logic [7:0]  st;

   assign reads_dec = reads_left_ff - 16'd1;
   assign st        = req.bus_status;

   always_comb begin
      phase_in        = phase_ff;
      writes_left_in  = writes_left_ff;
      reads_left_in   = reads_left_ff;
      wrote_flag_in   = wrote_flag_ff;
      address_byte_in = address_byte_ff;
      rsp             = '0;

      case (req.kind)
         KIND_BEGIN: begin
            if (phase_ff == PH_IDLE) begin
               address_byte_in = req.device_address;
               writes_left_in  = req.write_count;
               reads_left_in   = req.read_count;
               wrote_flag_in   = |req.write_count;
               if (|req.write_count) begin
                  rsp.action = ACT_START;
                  phase_in   = PH_W_START;
               end else if (|req.read_count) begin
                  rsp.action = ACT_START;
                  phase_in   = PH_R_START;
               end else begin
                  rsp.done_res = 1'b1;
               end
            end
         end
         KIND_WRITE: begin
            if (phase_ff == PH_W_NEED) begin
               rsp.action        = ACT_TX;
               rsp.transmit_byte = req.write_byte;
               writes_left_in    = writes_left_ff - 16'd1;
               phase_in          = PH_W_DATA;
            end
         end
         KIND_BUS: begin
            unique case (phase_ff)
               PH_W_START: begin
                  if (st == ST_START) begin
                     rsp.action        = ACT_TX;
                     rsp.transmit_byte = address_byte_ff & ADDR_WR_MASK;
                     phase_in          = PH_W_SLA;
                  end else begin
                     rsp.done_res       = 1'b1;
                     rsp.outcome        = OUT_ERROR;
                     rsp.failing_status = st;
                     phase_in           = PH_IDLE;
                  end
               end
               PH_W_SLA, PH_W_DATA: begin
                  if ((phase_ff == PH_W_SLA && st == ST_SLAW_ACK) ||
                      (phase_ff == PH_W_DATA && st == ST_TX_ACK)) begin
                     if (|writes_left_ff) begin
                        rsp.action = ACT_REQ;
                        phase_in   = PH_W_NEED;
                     end else if (|reads_left_ff) begin
                        rsp.action = ACT_START;
                        phase_in   = PH_R_START;
                     end else begin
                        rsp.action   = ACT_STOP;
                        rsp.done_res = 1'b1;
                        phase_in     = PH_IDLE;
                     end
                  end else if ((phase_ff == PH_W_SLA && st == ST_SLAW_NAK) ||
                               (phase_ff == PH_W_DATA && st == ST_TX_NAK)) begin
                     rsp.action         = ACT_STOP;
                     rsp.done_res       = 1'b1;
                     rsp.outcome        = OUT_NAK;
                     rsp.failing_status = st;
                     phase_in           = PH_IDLE;
                  end else begin
                     rsp.done_res       = 1'b1;
                     rsp.outcome        = OUT_ERROR;
                     rsp.failing_status = st;
                     phase_in           = PH_IDLE;
                  end
               end
               PH_R_START: begin
                  if (st == (wrote_flag_ff ? ST_RSTART : ST_START)) begin
                     rsp.action        = ACT_TX;
                     rsp.transmit_byte = address_byte_ff | 8'h01;
                     phase_in          = PH_R_SLA;
                  end else begin
                     rsp.done_res       = 1'b1;
                     rsp.outcome        = OUT_ERROR;
                     rsp.failing_status = st;
                     phase_in           = PH_IDLE;
                  end
               end
               PH_R_SLA: begin
                  if (st == ST_SLAR_ACK) begin
                     if (reads_left_ff > 16'd1) begin
                        rsp.action = ACT_RX_ACK;
                        phase_in   = PH_R_ACK;
                     end else begin
                        rsp.action = ACT_RX_NACK;
                        phase_in   = PH_R_NACK;
                     end
                  end else if (st == ST_SLAR_NAK) begin
                     rsp.action         = ACT_STOP;
                     rsp.done_res       = 1'b1;
                     rsp.outcome        = OUT_NAK;
                     rsp.failing_status = st;
                     phase_in           = PH_IDLE;
                  end else begin
                     rsp.done_res       = 1'b1;
                     rsp.outcome        = OUT_ERROR;
                     rsp.failing_status = st;
                     phase_in           = PH_IDLE;
                  end
               end
               PH_R_ACK: begin
                  if (st == ST_RX_ACK) begin
                     rsp.read_byte  = req.received_byte;
                     rsp.read_valid = 1'b1;
                     reads_left_in  = reads_dec;
                     if (reads_dec > 16'd1) begin
                        rsp.action = ACT_RX_ACK;
                        phase_in   = PH_R_ACK;
                     end else begin
                        rsp.action = ACT_RX_NACK;
                        phase_in   = PH_R_NACK;
                     end
                  end else begin
                     rsp.done_res       = 1'b1;
                     rsp.outcome        = OUT_ERROR;
                     rsp.failing_status = st;
                     phase_in           = PH_IDLE;
                  end
               end
               PH_R_NACK: begin
                  if (st == ST_RX_NACK) begin
                     rsp.read_byte  = req.received_byte;
                     rsp.read_valid = 1'b1;
                     reads_left_in  = '0;
                     rsp.action     = ACT_STOP;
                     rsp.done_res   = 1'b1;
                     phase_in       = PH_IDLE;
                  end else begin
                     rsp.done_res       = 1'b1;
                     rsp.outcome        = OUT_ERROR;
                     rsp.failing_status = st;
                     phase_in           = PH_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         writes_left_ff  <= '0;
         reads_left_ff   <= '0;
         wrote_flag_ff   <= 1'b0;
         address_byte_ff <= '0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         writes_left_ff  <= writes_left_in;
         reads_left_ff   <= reads_left_in;
         wrote_flag_ff   <= wrote_flag_in;
         address_byte_ff <= address_byte_in;
      end
   end

`ifndef SYNTH
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && rsp.done_res |=> phase_ff == PH_IDLE)
      else $error("transaction end did not return to idle");

   a_rx_phase: assert property (@(posedge clock) disable iff (reset)
      rsp.read_valid |-> (phase_ff == PH_R_ACK || phase_ff == PH_R_NACK))
      else $error("read data outside a receive phase");

   a_nak_stop: assert property (@(posedge clock) disable iff (reset)
      rsp.outcome == OUT_NAK |-> rsp.action == ACT_STOP && rsp.done_res)
      else $error("NAK outcome without STOP");

   a_rstart: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_W_SLA && rsp.action == ACT_START
      |=> phase_ff == PH_R_START && wrote_flag_ff)
      else $error("repeated START without prior writes");
`endif

endmodule

`default_nettype wire
